// ===== sv/kps_pkg.sv =====
package kps_pkg;

  // matrix geometry and key codes
  localparam int ROWS = 3;
  localparam int COLS = 3;
  localparam int NKEYS = ROWS * COLS;
  localparam int KEY_W = 4;
  localparam logic [KEY_W-1:0] POWER_ID = 4'd9;

  // counter widths
  localparam int DIV_W = 4;
  localparam int IVL_W = 10;
  localparam int ELAPSED_W = 11;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 11'd2047;
  localparam int PWR_W = 16;
  localparam int GUARD_W = 8;

  // stream and configuration widths
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_DIVIDER = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPORT_INTERVAL = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_TICKS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_RELEASE_TICKS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_GUARD = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_GLITCH_TICKS = 3'd6;

  // register reset values
  localparam logic [DIV_W-1:0] RST_SCAN_DIVIDER = 4'd4;
  localparam logic [IVL_W-1:0] RST_REPORT_INTERVAL = 10'd40;
  localparam logic [IVL_W-1:0] RST_DEBOUNCE_TICKS = 10'd4;
  localparam logic [PWR_W-1:0] RST_LONG_PRESS_TICKS = 16'd100;
  localparam logic [PWR_W-1:0] RST_LONG_RELEASE_TICKS = 16'd200;
  localparam logic [GUARD_W-1:0] RST_RELEASE_GUARD = 8'd100;
  localparam logic [GUARD_W-1:0] RST_GLITCH_TICKS = 8'd2;

  // events per tick and queue depth
  localparam int MAX_EVENTS = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key_id;
    logic             pressed;
  } kps_event_t;

  // one tick's events, slot 0 first; cnt is 1 to 3
  typedef struct packed {
    logic [1:0]                       cnt;
    kps_event_t [MAX_EVENTS-1:0]      ev;
  } kps_entry_t;

endpackage

// ===== sv/kps_front.sv =====
module kps_front
  import kps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  tick_fire,
  input  logic [NKEYS-1:0]      matrix_pressed,
  input  logic                  power_pressed,
  input  logic                  deep_sleep,
  output logic                  push,
  output kps_entry_t            push_entry
);

  // configuration registers
  logic [DIV_W-1:0]     scan_div_r;
  logic [IVL_W-1:0]     interval_r;
  logic [IVL_W-1:0]     debounce_r;
  logic [PWR_W-1:0]     long_press_r;
  logic [PWR_W-1:0]     long_release_r;
  logic [GUARD_W-1:0]   rel_guard_r;
  logic [GUARD_W-1:0]   glitch_r;

  // tick state
  logic [DIV_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic                 tracking_r, tracking_nxt;
  logic                 await_r, await_nxt;
  logic [KEY_W-1:0]     held_key_r, held_key_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [PWR_W-1:0]     pcount_r, pcount_nxt;
  logic [GUARD_W-1:0]   guard_r, guard_nxt;

  logic [ELAPSED_W-1:0] el_inc;
  logic [DIV_W-1:0]     div_inc;
  logic                 run_scan;
  logic                 held_down;
  logic                 any_key;
  logic [KEY_W-1:0]     first_key;
  logic [IVL_W-1:0]     gap;
  logic                 m_ev;
  logic                 m_pressed;
  logic [PWR_W-1:0]     pc_inc;
  logic                 lp_hit, lr_hit;
  logic [GUARD_W-1:0]   guard_dec;
  logic [1:0]           p_cnt;
  logic                 p0_pressed;
  kps_event_t           m_event, p0_event, p1_event;

  // first pressed key in row-major order
  always_comb begin
    any_key = 1'b0;
    first_key = '0;
    for (int i = NKEYS - 1; i >= 0; i--) begin
      if (matrix_pressed[i]) begin
        any_key = 1'b1;
        first_key = KEY_W'(i);
      end
    end
  end

  // matrix side
  always_comb begin
    el_inc = (elapsed_r != ELAPSED_MAX) ? elapsed_r + 1'b1 : elapsed_r;
    div_inc = div_cnt_r + 1'b1;
    run_scan = (div_inc >= scan_div_r);
    held_down = matrix_pressed[held_key_r];
    gap = (debounce_r > interval_r) ? '0 : interval_r - debounce_r;
    div_cnt_nxt = run_scan ? '0 : div_inc;
    tracking_nxt = tracking_r;
    await_nxt = await_r;
    held_key_nxt = held_key_r;
    elapsed_nxt = el_inc;
    m_ev = 1'b0;
    m_pressed = 1'b0;
    if (run_scan) begin
      if (tracking_r) begin
        if (await_r) begin
          if (!held_down) begin
            // released during debounce, dropped quietly
            tracking_nxt = 1'b0;
            await_nxt = 1'b0;
          end else if (el_inc > {1'b0, interval_r}) begin
            await_nxt = 1'b0;
            elapsed_nxt = '0;
            m_ev = 1'b1;
            m_pressed = 1'b1;
          end
        end else if (!held_down) begin
          elapsed_nxt = '0;
          tracking_nxt = 1'b0;
          m_ev = 1'b1;
        end
      end else if (any_key) begin
        held_key_nxt = first_key;
        await_nxt = 1'b1;
        tracking_nxt = 1'b1;
        if (el_inc > {1'b0, gap}) begin
          elapsed_nxt = {1'b0, gap};
        end
      end
    end
  end

  // power key side
  always_comb begin
    pc_inc = pcount_r + 1'b1;
    lp_hit = (pc_inc == long_press_r);
    lr_hit = (pc_inc == long_release_r);
    guard_dec = (guard_r != '0) ? guard_r - 1'b1 : guard_r;
    pcount_nxt = pcount_r;
    guard_nxt = guard_r;
    p_cnt = 2'd0;
    p0_pressed = 1'b1;
    if (power_pressed) begin
      pcount_nxt = pc_inc;
      p0_pressed = lp_hit;
      if (lp_hit || lr_hit) begin
        guard_nxt = rel_guard_r;
      end
      if (lr_hit) begin
        pcount_nxt = '0;
      end
      p_cnt = {1'b0, lp_hit} + {1'b0, lr_hit};
    end else begin
      guard_nxt = guard_dec;
      if (pcount_r > {{(PWR_W-GUARD_W){1'b0}}, glitch_r}) begin
        pcount_nxt = '0;
        // short click, down then up
        if (!deep_sleep && guard_dec == '0) begin
          p_cnt = 2'd2;
        end
      end
    end
  end

  // pack the tick's events in order
  always_comb begin
    m_event.key_id = held_key_r;
    m_event.pressed = m_pressed;
    p0_event.key_id = POWER_ID;
    p0_event.pressed = p0_pressed;
    p1_event.key_id = POWER_ID;
    p1_event.pressed = 1'b0;
    if (m_ev) begin
      push_entry.ev = {p1_event, p0_event, m_event};
    end else begin
      push_entry.ev = {p1_event, p1_event, p0_event};
    end
    push_entry.cnt = {1'b0, m_ev} + p_cnt;
    push = tick_fire && (m_ev || (p_cnt != 2'd0));
  end

  // configuration writes and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_div_r <= RST_SCAN_DIVIDER;
      interval_r <= RST_REPORT_INTERVAL;
      debounce_r <= RST_DEBOUNCE_TICKS;
      long_press_r <= RST_LONG_PRESS_TICKS;
      long_release_r <= RST_LONG_RELEASE_TICKS;
      rel_guard_r <= RST_RELEASE_GUARD;
      glitch_r <= RST_GLITCH_TICKS;
      div_cnt_r <= '0;
      tracking_r <= 1'b0;
      await_r <= 1'b0;
      held_key_r <= '0;
      elapsed_r <= ELAPSED_MAX;
      pcount_r <= '0;
      guard_r <= RST_RELEASE_GUARD;
    end else begin
      if (cfg_valid) begin
        case (cfg_addr)
          REG_SCAN_DIVIDER:       scan_div_r <= cfg_data[DIV_W-1:0];
          REG_REPORT_INTERVAL:    interval_r <= cfg_data[IVL_W-1:0];
          REG_DEBOUNCE_TICKS:     debounce_r <= cfg_data[IVL_W-1:0];
          REG_LONG_PRESS_TICKS:   long_press_r <= cfg_data[PWR_W-1:0];
          REG_LONG_RELEASE_TICKS: long_release_r <= cfg_data[PWR_W-1:0];
          REG_RELEASE_GUARD:      rel_guard_r <= cfg_data[GUARD_W-1:0];
          REG_GLITCH_TICKS:       glitch_r <= cfg_data[GUARD_W-1:0];
          default: ;
        endcase
      end
      if (tick_fire) begin
        div_cnt_r <= div_cnt_nxt;
        tracking_r <= tracking_nxt;
        await_r <= await_nxt;
        held_key_r <= held_key_nxt;
        elapsed_r <= elapsed_nxt;
        pcount_r <= pcount_nxt;
        guard_r <= guard_nxt;
      end
    end
  end

endmodule

// ===== sv/kps_queue.sv =====
module kps_queue
  import kps_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  kps_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output kps_entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kps_entry_t         store_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = store_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/kps_back.sv =====
module kps_back
  import kps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  kps_entry_t             head_entry,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  kps_entry_t        ent_r;
  logic              ent_valid_r;
  logic [1:0]        pos_r;
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic              out_pressed_r;
  logic              out_last_r;

  logic              load;
  logic              is_last;
  kps_event_t        cur_ev;

  // pick the next event of the held entry
  always_comb begin
    cur_ev = ent_r.ev[pos_r];
    is_last = (pos_r == ent_r.cnt - 2'd1);
    load = ent_valid_r && (!out_valid_r || out_tready);
    pop = head_valid && (!ent_valid_r || (load && is_last));
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(OUT_TDATA_W-KEY_W){1'b0}}, out_key_r};
  assign out_tuser = out_pressed_r;
  assign out_tlast = out_last_r;

  // entry payload and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head_entry;
    end
    if (load) begin
      out_key_r <= cur_ev.key_id;
      out_pressed_r <= cur_ev.pressed;
      out_last_r <= is_last;
    end
  end

  // serialiser control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        ent_valid_r <= 1'b1;
        pos_r <= '0;
      end else if (load) begin
        pos_r <= pos_r + 1'b1;
        if (is_last) begin
          ent_valid_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/keypad_scan_with_power_key_unit.sv =====
// a tick's events pass in turn through the event queue, the entry register and the output register
// throughput: one tick beat per cycle while the event queue has room; events leave one
// per cycle through the single output register while out_tready is high
// reset: synchronous, active-low rst_n; registers take their defaults, elapsed saturates,
// guard loads the release guard default, queue and output empty
module keypad_scan_with_power_key_unit
  import kps_pkg::*;
#(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: matrix_pressed [8:0], power_pressed [9], deep_sleep [10], zero fill
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: key_id [3:0], zero fill
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: pressed [0]
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic       tick_fire;
  logic       push, full, pop, head_valid;
  kps_entry_t push_entry, head_entry;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign tick_fire = in_tvalid && in_tready;

  // tick classification and state update
  kps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .tick_fire      (tick_fire),
    .matrix_pressed (in_tdata[NKEYS-1:0]),
    .power_pressed  (in_tdata[NKEYS]),
    .deep_sleep     (in_tdata[NKEYS+1]),
    .push           (push),
    .push_entry     (push_entry)
  );

  // per-tick event queue
  kps_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // event serialiser and output register
  kps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import kps_pkg::*;

  localparam int MAX_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // one predicted output beat
  typedef struct packed {
    kps_event_t ev;
    logic       last;
  } expected_event_t;

  // shadow of the keypad and power key logic plus the queue of predicted events
  class key_event_scoreboard;
    logic [DIV_W-1:0]     scan_div;
    logic [IVL_W-1:0]     rpt_ivl;
    logic [IVL_W-1:0]     deb_ticks;
    logic [PWR_W-1:0]     lp_ticks;
    logic [PWR_W-1:0]     lr_ticks;
    logic [GUARD_W-1:0]   guard_rld;
    logic [GUARD_W-1:0]   glitch_lim;
    logic [DIV_W-1:0]     div_cnt;
    bit                   tracking;
    bit                   awaiting;
    logic [KEY_W-1:0]     held_key;
    logic [ELAPSED_W-1:0] elapsed;
    logic [PWR_W-1:0]     pwr_cnt;
    logic [GUARD_W-1:0]   guard_cnt;
    expected_event_t      expected_events[$];
    int                   errors;
    int                   ticks;
    int                   matrix_events;
    int                   power_events;
    int                   settings;

    function new();
      scan_div = RST_SCAN_DIVIDER;
      rpt_ivl = RST_REPORT_INTERVAL;
      deb_ticks = RST_DEBOUNCE_TICKS;
      lp_ticks = RST_LONG_PRESS_TICKS;
      lr_ticks = RST_LONG_RELEASE_TICKS;
      guard_rld = RST_RELEASE_GUARD;
      glitch_lim = RST_GLITCH_TICKS;
      div_cnt = '0;
      tracking = 0;
      awaiting = 0;
      held_key = '0;
      elapsed = ELAPSED_MAX;
      pwr_cnt = '0;
      guard_cnt = RST_RELEASE_GUARD;
      errors = 0;
      ticks = 0;
      matrix_events = 0;
      power_events = 0;
      settings = 1;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SCAN_DIVIDER:       scan_div = val[DIV_W-1:0];
        REG_REPORT_INTERVAL:    rpt_ivl = val[IVL_W-1:0];
        REG_DEBOUNCE_TICKS:     deb_ticks = val[IVL_W-1:0];
        REG_LONG_PRESS_TICKS:   lp_ticks = val[PWR_W-1:0];
        REG_LONG_RELEASE_TICKS: lr_ticks = val[PWR_W-1:0];
        REG_RELEASE_GUARD:      guard_rld = val[GUARD_W-1:0];
        REG_GLITCH_TICKS:       glitch_lim = val[GUARD_W-1:0];
        default: ;
      endcase
    endfunction

    function kps_event_t make_ev(logic [KEY_W-1:0] id, logic down);
      kps_event_t ev;
      ev.key_id = id;
      ev.pressed = down;
      return ev;
    endfunction

    // predict the events of one accepted tick beat
    function void note_tick(logic [IN_TDATA_W-1:0] beat);
      kps_event_t      evs[$];
      expected_event_t exp_ev;
      logic [NKEYS-1:0] keys;
      logic [IVL_W-1:0] gap;
      bit held;
      bit deep;
      bit found;
      keys = beat[NKEYS-1:0];
      held = beat[NKEYS];
      deep = beat[NKEYS+1];
      ticks++;
      if (elapsed < ELAPSED_MAX) elapsed++;

      // matrix side, once every scan_div ticks, or every tick when scan_div is 0
      div_cnt++;
      if (div_cnt >= scan_div) begin
        div_cnt = '0;
        if (tracking) begin
          if (awaiting) begin
            if (!keys[held_key]) begin
              // released during debounce, dropped silently
              tracking = 0;
              awaiting = 0;
            end else if (elapsed > {1'b0, rpt_ivl}) begin
              awaiting = 0;
              elapsed = '0;
              evs.push_back(make_ev(held_key, 1'b1));
              matrix_events++;
            end
          end else if (!keys[held_key]) begin
            elapsed = '0;
            evs.push_back(make_ev(held_key, 1'b0));
            matrix_events++;
            tracking = 0;
          end
        end else begin
          // first pressed key in row-major order
          found = 0;
          gap = (deb_ticks > rpt_ivl) ? '0 : rpt_ivl - deb_ticks;
          for (int i = 0; i < NKEYS; i++) begin
            if (!found && keys[i]) begin
              found = 1;
              held_key = KEY_W'(i);
              awaiting = 1;
              tracking = 1;
              if (elapsed > {1'b0, gap}) elapsed = {1'b0, gap};
            end
          end
        end
      end

      // power key side
      if (held) begin
        pwr_cnt++;
        if (pwr_cnt == lp_ticks) begin
          evs.push_back(make_ev(POWER_ID, 1'b1));
          power_events++;
          guard_cnt = guard_rld;
        end
        if (pwr_cnt == lr_ticks) begin
          evs.push_back(make_ev(POWER_ID, 1'b0));
          power_events++;
          guard_cnt = guard_rld;
          pwr_cnt = '0;
        end
      end else begin
        if (guard_cnt != '0) guard_cnt--;
        if (pwr_cnt > {8'b0, glitch_lim}) begin
          pwr_cnt = '0;
          if (!deep && guard_cnt == '0) begin
            evs.push_back(make_ev(POWER_ID, 1'b1));
            evs.push_back(make_ev(POWER_ID, 1'b0));
            power_events += 2;
          end
        end
      end

      foreach (evs[i]) begin
        exp_ev.ev = evs[i];
        exp_ev.last = (i == evs.size() - 1);
        expected_events.push_back(exp_ev);
      end
    endfunction

    // compare one accepted output beat with the oldest prediction
    function void check_event(logic [OUT_TDATA_W-1:0] tdata, logic tuser, logic tlast);
      expected_event_t exp_ev;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got tdata %0h pressed %0b last %0b",
                 $time, tdata, tuser, tlast);
        return;
      end
      exp_ev = expected_events.pop_front();
      if (tdata !== {{(OUT_TDATA_W-KEY_W){1'b0}}, exp_ev.ev.key_id} ||
          tuser !== exp_ev.ev.pressed || tlast !== exp_ev.last) begin
        errors++;
        $display("%0t: mismatch, expected key %0d pressed %0b last %0b,",
                 $time, exp_ev.ev.key_id, exp_ev.ev.pressed, exp_ev.last,
                 " got tdata %0h pressed %0b last %0b", tdata, tuser, tlast);
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void report_leftovers();
      if (expected_events.size() != 0) begin
        errors += expected_events.size();
        $display("%0t: %0d expected beats never arrived, oldest key %0d pressed %0b",
                 $time, expected_events.size(), expected_events[0].ev.key_id,
                 expected_events[0].ev.pressed);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;

  key_event_scoreboard sb;

  // stimulus state carried across phases
  logic [NKEYS-1:0] cur_keys;
  logic             cur_pwr;
  int               keys_run_left;
  int               pwr_left;
  int               gap_max;
  int               burst_left;

  // receiver state
  int       hold_req;
  int       hold_left;
  rx_mode_t rx_mode;
  int       rx_left;
  int       rx_phase;
  int       cycle_count;

  keypad_scan_with_power_key_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // beat monitors on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_event(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) sb.note_tick(in_tdata);
    end
  end

  // receiver: stall patterns, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= (rx_phase % 4 == 0);
        default:   out_tready <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] tick_beat(logic [NKEYS-1:0] keys, logic pwr,
                                                      logic deep);
    logic [IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[NKEYS-1:0] = keys;
    beat[NKEYS] = pwr;
    beat[NKEYS+1] = deep;
    return beat;
  endfunction

  // offer one tick beat, with bursts and gaps
  task automatic send_tick(logic [IN_TDATA_W-1:0] beat);
    int n_gap;
    if (gap_max > 0 && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      n_gap = $urandom_range(1, gap_max);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n_gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // wait for every predicted event, then let in-flight ticks settle
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_ADDR_W-1:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic apply_settings(int div, int ivl, int deb, int lp, int lr, int guard,
                                int glitch);
    put_reg(REG_SCAN_DIVIDER, div);
    put_reg(REG_REPORT_INTERVAL, ivl);
    put_reg(REG_DEBOUNCE_TICKS, deb);
    put_reg(REG_LONG_PRESS_TICKS, lp);
    put_reg(REG_LONG_RELEASE_TICKS, lr);
    put_reg(REG_RELEASE_GUARD, guard);
    put_reg(REG_GLITCH_TICKS, glitch);
    @(negedge clk);
    cfg_valid <= 1'b0;
    sb.settings++;
  endtask

  // held keys and power levels that persist for random runs, with one-tick noise
  task automatic run_ticks(int n, int key_run_max, int pwr_run_max, int deep_pct,
                           int noise_pct);
    logic [NKEYS-1:0] keys;
    logic             deep;
    int               r;
    for (int i = 0; i < n; i++) begin
      if (keys_run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 45) cur_keys = '0;
        else if (r < 80) cur_keys = NKEYS'(1) << $urandom_range(0, NKEYS - 1);
        else cur_keys = NKEYS'($urandom_range(0, (1 << NKEYS) - 1));
        keys_run_left = $urandom_range(1, key_run_max);
      end
      if (pwr_left == 0) begin
        cur_pwr = ~cur_pwr;
        pwr_left = $urandom_range(1, pwr_run_max);
      end
      keys = cur_keys;
      if ($urandom_range(0, 99) < noise_pct) keys = NKEYS'($urandom_range(0, (1 << NKEYS) - 1));
      deep = ($urandom_range(0, 99) < deep_pct);
      send_tick(tick_beat(keys, cur_pwr, deep));
      keys_run_left--;
      pwr_left--;
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    cur_keys = '0;
    cur_pwr = 1'b0;
    keys_run_left = 0;
    pwr_left = 0;
    gap_max = 2;
    burst_left = 0;
    hold_req = 0;
    hold_left = 0;
    rx_mode = RX_OPEN;
    rx_left = 0;
    rx_phase = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, ending with the power key released
    send_tick(tick_beat(9'h1FF, 1'b1, 1'b0));
    send_tick(tick_beat(9'h000, 1'b1, 1'b1));
    send_tick(tick_beat(9'h100, 1'b1, 1'b0));
    send_tick(tick_beat(9'h000, 1'b0, 1'b0));
    stop_sending();
    wait_drained();

    // directed: matrix every tick, short debounce, equal long limits, no guard
    apply_settings(0, 2, 1, 3, 3, 0, 1);
    // key 4 reaches its press and release, power down and up on the same tick
    send_tick(tick_beat(9'h010, 1'b1, 1'b0));
    send_tick(tick_beat(9'h010, 1'b1, 1'b0));
    send_tick(tick_beat(9'h010, 1'b1, 1'b0));
    send_tick(tick_beat(9'h000, 1'b0, 1'b1));
    // key 8 let go during debounce, short power hold kept under the glitch limit
    send_tick(tick_beat(9'h100, 1'b1, 1'b0));
    send_tick(tick_beat(9'h000, 1'b0, 1'b0));
    // kept count tops the glitch limit, click hidden by deep sleep
    send_tick(tick_beat(9'h000, 1'b1, 1'b0));
    send_tick(tick_beat(9'h000, 1'b0, 1'b1));
    // clean click
    send_tick(tick_beat(9'h000, 1'b1, 1'b0));
    send_tick(tick_beat(9'h000, 1'b1, 1'b0));
    send_tick(tick_beat(9'h000, 1'b0, 1'b0));
    // every key down: key 0 wins, then only key 0 lets go
    send_tick(tick_beat(9'h1FF, 1'b0, 1'b0));
    send_tick(tick_beat(9'h1FF, 1'b0, 1'b0));
    send_tick(tick_beat(9'h1FF, 1'b0, 1'b0));
    send_tick(tick_beat(9'h1FE, 1'b0, 1'b0));
    send_tick(tick_beat(9'h1FE, 1'b0, 1'b1));
    send_tick(tick_beat(9'h1FE, 1'b1, 1'b1));
    send_tick(tick_beat(9'h1FE, 1'b0, 1'b0));
    send_tick(tick_beat(9'h000, 1'b0, 1'b0));
    stop_sending();
    wait_drained();

    // busy settings: receiver holds off while the sender keeps offering
    apply_settings(0, 1, 0, 2, 3, 0, 0);
    gap_max = 0;
    hold_req = 1;
    run_ticks(40, 2, 2, 10, 0);
    // sender waits for every event before going on
    stop_sending();
    while (sb.pending() != 0) @(posedge clk);
    gap_max = 4;
    run_ticks(30, 3, 3, 10, 5);
    stop_sending();
    wait_drained();

    // short limits, long release above long press
    apply_settings(1, 3, 0, 4, 7, 3, 1);
    gap_max = 3;
    run_ticks(70, 8, 10, 20, 5);
    stop_sending();
    wait_drained();

    // slowest divider, debounce above interval, glitch and guard at top
    apply_settings(15, 1, 1023, 1, 2, 255, 255);
    gap_max = 6;
    run_ticks(60, 40, 6, 20, 5);
    stop_sending();
    wait_drained();

    // divider lowered to zero, no guard, no glitch filter
    apply_settings(0, 20, 5, 8, 12, 0, 0);
    gap_max = 2;
    run_ticks(70, 30, 16, 30, 5);
    stop_sending();
    wait_drained();

    // release limit under press limit, debounce equal to interval
    apply_settings(5, 8, 8, 12, 5, 10, 3);
    gap_max = 5;
    run_ticks(60, 20, 10, 20, 5);
    stop_sending();
    wait_drained();

    // longest interval and debounce, long limits at top
    apply_settings(15, 1023, 1023, 65535, 65535, 255, 255);
    gap_max = 0;
    run_ticks(20, 3000, 4, 20, 0);
    stop_sending();
    wait_drained();

    sb.report_leftovers();
    $display("covered %0d ticks over %0d register settings", sb.ticks, sb.settings);
    $display("predicted %0d matrix and %0d power events, %0d errors",
             sb.matrix_events, sb.power_events, sb.errors);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
